// ===== rtl/rrts_pkg.sv =====
package rrts_pkg;

  typedef enum logic [2:0] {
    CMD_READY    = 3'd0,
    CMD_SLEEP    = 3'd1,
    CMD_TWAIT    = 3'd2,
    CMD_SCHED    = 3'd3,
    CMD_TICK     = 3'd4,
    CMD_TCHECK   = 3'd5,
    CMD_SETCUR   = 3'd6,
    CMD_NOP      = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_SWITCH  = 3'd0,
    KIND_NOSW    = 3'd1,
    KIND_NOCUR   = 3'd2,
    KIND_SLEPT   = 3'd3,
    KIND_TIMEOUT = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    PH_UNUSED = 3'd0,
    PH_READY  = 3'd1,
    PH_SLEEP  = 3'd2,
    PH_WAIT   = 3'd3,
    PH_RUN    = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK_RD,
    ST_WALK_EV,
    ST_EMIT,
    ST_DONE
  } state_e;

  localparam int unsigned MaxResults = 16;

endpackage

// ===== rtl/rrts_ram.sv =====
module rrts_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/round_robin_task_scheduler.sv =====
// Round-robin task scheduler.
// Input channel s_axis: one command per transfer (cmd, task_slot, ticks,
// time_value). Output channel m_axis: result transfers (kind in tuser,
// slot in tdata, tlast on the final result of a command).
// idle_task is written through cfg_we_i/cfg_wdata_i; the user must do so only while the
// block is idle, which the block itself does not check. One command is taken at a time;
// s_axis_tready is low until the command is finished and all its results have been taken.
// Ready, sleep, timed wait and set current go from the accept to a done state;
// schedule sends its result before its done state. Tick and time check walk the
// list one entry at a time (read of the link/value RAM, then evaluate) on one
// shared decrement/compare unit, then take the end check, the final result if any
// and a done state.
// A woken task, up to MaxResults per command, is held as the pending result; the
// next wake sends it out with tlast low, the end of the walk sends it with tlast high.
// A stalled receiver holds the walk on the entry that found the next wake, or
// holds the final result; m_axis_tvalid stays high until the transfer.
// Reset clears the queue, both lists, all phases and the current task;
// the value and link RAMs need no clearing.
module round_robin_task_scheduler #(
  parameter int unsigned MAX_TASKS = 16,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [3:0]   cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [2:0] cmd, [6:3] task_slot, [38:7] ticks, [70:39] time_value, zero fill
  input  logic [71:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [3:0] slot_out, zero fill
  output logic [7:0]   m_axis_tdata,
  // [2:0] kind
  output logic [2:0]   m_axis_tuser,
  output logic         m_axis_tlast
);

  localparam int unsigned SW = $clog2(MAX_TASKS);
  localparam int unsigned PW = SW + 1;
  localparam int unsigned VW = (TIME_BITS > 32) ? TIME_BITS : 32;

  typedef logic [SW-1:0] slot_t;
  typedef logic [PW-1:0] ptr_t;

  localparam ptr_t NoneSlot = ptr_t'(MAX_TASKS);

  rrts_pkg::state_e state_q, state_d;
  rrts_pkg::phase_e phase_q [MAX_TASKS];
  slot_t ring_q [MAX_TASKS];
  slot_t rhead_q;
  ptr_t  rcount_q;
  ptr_t  shead_q, stail_q, whead_q, wtail_q, cur_q;
  logic [3:0] idle_q;

  logic [2:0]  cmd_q;
  ptr_t        slot_q;
  logic [TIME_BITS-1:0] tv_q;
  ptr_t  wcur_q, wprev_q;
  logic [PW:0] steps_q;
  logic [4:0] nres_q;
  logic [2:0] okind_q;
  slot_t oslot_q;

  logic [2:0]  in_cmd;
  logic [3:0]  in_slot;
  logic [31:0] in_tv;
  logic [TIME_BITS-1:0] in_tvm;
  logic        acc, out_acc;
  assign in_cmd  = s_axis_tdata[2:0];
  assign in_slot = s_axis_tdata[6:3];
  assign in_tv   = s_axis_tdata[70:39];
  assign in_tvm  = TIME_BITS'(in_tv);
  assign acc     = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (state_q == rrts_pkg::ST_IDLE);

  logic slot_ok;
  assign slot_ok = (32'(in_slot) < MAX_TASKS);
  slot_t in_s;
  assign in_s = SW'(in_slot);

  // value RAM: sleep counts (lower half) and wake times (upper half)
  logic            vwe;
  logic [SW:0]     vwaddr, vraddr;
  logic [VW-1:0]   vwdata, vrdata;
  logic            lwe;
  logic [SW:0]     lwaddr, lraddr;
  ptr_t            lwdata, lrdata;

  rrts_ram #(.Width(VW), .Depth(1 << PW)) u_val (
    .clk_i(clk_i), .we_i(vwe), .waddr_i(vwaddr), .wdata_i(vwdata),
    .raddr_i(vraddr), .rdata_o(vrdata)
  );
  rrts_ram #(.Width(PW), .Depth(1 << PW)) u_link (
    .clk_i(clk_i), .we_i(lwe), .waddr_i(lwaddr), .wdata_i(lwdata),
    .raddr_i(lraddr), .rdata_o(lrdata)
  );

  logic mode;
  assign mode = (cmd_q == rrts_pkg::CMD_TCHECK);
  slot_t wc;
  assign wc = wcur_q[SW-1:0];

  // shared evaluation unit: decrement or compare
  logic [31:0] dec;
  logic        wake;
  ptr_t        nxt;
  assign dec  = vrdata[31:0] - 32'd1;
  assign wake = mode ? (tv_q >= vrdata[TIME_BITS-1:0]) : (dec == 32'd0);
  assign nxt  = (lrdata > NoneSlot) ? NoneSlot : lrdata;

  logic pend_q;
  logic emit_now, flush, ev_go;
  assign emit_now = wake && (nres_q < 5'(rrts_pkg::MaxResults));
  assign flush    = (state_q == rrts_pkg::ST_WALK_EV) && emit_now && pend_q;
  assign ev_go    = (state_q == rrts_pkg::ST_WALK_EV) && (!flush || m_axis_tready);

  // schedule decision
  slot_t idle_s;
  assign idle_s = (32'(idle_q) < MAX_TASKS) ? SW'(idle_q) : slot_t'(MAX_TASKS - 1);
  slot_t cs;
  assign cs = cur_q[SW-1:0];
  slot_t nsel;
  logic  fromq;
  always_comb begin
    fromq = (rcount_q != '0);
    if (fromq) nsel = ring_q[rhead_q];
    else if (phase_q[cs] == rrts_pkg::PH_RUN) nsel = cs;
    else nsel = idle_s;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rrts_pkg::ST_IDLE: begin
        if (acc) begin
          if (in_cmd == rrts_pkg::CMD_TICK || in_cmd == rrts_pkg::CMD_TCHECK)
            state_d = rrts_pkg::ST_WALK_RD;
          else if (in_cmd == rrts_pkg::CMD_SCHED) state_d = rrts_pkg::ST_EMIT;
          else state_d = rrts_pkg::ST_DONE;
        end
      end
      rrts_pkg::ST_WALK_RD: begin
        if (wcur_q >= NoneSlot || steps_q >= (PW+1)'(MAX_TASKS)) begin
          state_d = (nres_q != '0) ? rrts_pkg::ST_EMIT : rrts_pkg::ST_DONE;
        end else begin
          state_d = rrts_pkg::ST_WALK_EV;
        end
      end
      rrts_pkg::ST_WALK_EV: if (ev_go) state_d = rrts_pkg::ST_WALK_RD;
      rrts_pkg::ST_EMIT: if (out_acc) state_d = rrts_pkg::ST_DONE;
      rrts_pkg::ST_DONE: state_d = rrts_pkg::ST_IDLE;
      default: state_d = rrts_pkg::ST_IDLE;
    endcase
  end

  // RAM ports
  always_comb begin
    vwe = 1'b0; vwaddr = '0; vwdata = '0;
    lwe = 1'b0; lwaddr = '0; lwdata = NoneSlot;
    vraddr = {mode, wc};
    lraddr = {mode, wc};
    if (state_q == rrts_pkg::ST_IDLE && acc && slot_ok) begin
      if (in_cmd == rrts_pkg::CMD_SLEEP) begin
        vwe = 1'b1; vwaddr = {1'b0, in_s}; vwdata = VW'(s_axis_tdata[38:7]);
      end else if (in_cmd == rrts_pkg::CMD_TWAIT) begin
        vwe = 1'b1; vwaddr = {1'b1, in_s};
        vwdata = VW'(in_tvm);
      end
      if (in_cmd == rrts_pkg::CMD_SLEEP || in_cmd == rrts_pkg::CMD_TWAIT) begin
        lwe = 1'b1; lwaddr = {in_cmd == rrts_pkg::CMD_TWAIT, in_s}; lwdata = NoneSlot;
      end
    end else if (state_q == rrts_pkg::ST_DONE && slot_q < NoneSlot &&
                 (cmd_q == rrts_pkg::CMD_SLEEP || cmd_q == rrts_pkg::CMD_TWAIT)) begin
      // link old tail to the new entry
      if (cmd_q == rrts_pkg::CMD_SLEEP && stail_q < NoneSlot) begin
        lwe = 1'b1; lwaddr = {1'b0, stail_q[SW-1:0]}; lwdata = slot_q;
      end else if (cmd_q == rrts_pkg::CMD_TWAIT && wtail_q < NoneSlot) begin
        lwe = 1'b1; lwaddr = {1'b1, wtail_q[SW-1:0]}; lwdata = slot_q;
      end
    end else if (ev_go) begin
      if (!mode) begin
        vwe = 1'b1; vwaddr = {1'b0, wc}; vwdata = VW'(dec);
      end
      if (wake && wprev_q < NoneSlot) begin
        lwe = 1'b1; lwaddr = {mode, wprev_q[SW-1:0]}; lwdata = nxt;
      end
    end
  end

  // ready push position
  logic [PW:0] rsum;
  slot_t rtail;
  assign rsum  = {2'b00, rhead_q} + {1'b0, rcount_q};
  assign rtail = (rsum >= (PW+1)'(MAX_TASKS)) ? SW'(rsum - (PW+1)'(MAX_TASKS)) : SW'(rsum);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= rrts_pkg::ST_IDLE;
    else state_q <= state_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        phase_q[i] <= rrts_pkg::PH_UNUSED;
        ring_q[i]  <= '0;
      end
      rhead_q <= '0; rcount_q <= '0;
      shead_q <= NoneSlot; stail_q <= NoneSlot;
      whead_q <= NoneSlot; wtail_q <= NoneSlot;
      cur_q <= NoneSlot; idle_q <= '0;
      nres_q <= '0;
      okind_q <= '0; oslot_q <= '0;
      wcur_q <= NoneSlot; wprev_q <= NoneSlot; steps_q <= '0;
    end else begin
      if (cfg_we_i) idle_q <= cfg_wdata_i;
      unique case (state_q)
        rrts_pkg::ST_IDLE: begin
          if (acc) begin
            nres_q <= '0;
            if (slot_ok) begin
              unique case (in_cmd)
                rrts_pkg::CMD_READY: begin
                  phase_q[in_s] <= rrts_pkg::PH_READY;
                  if (rcount_q < NoneSlot) begin
                    ring_q[rtail] <= in_s;
                    rcount_q <= rcount_q + 1'b1;
                  end
                end
                rrts_pkg::CMD_SLEEP: phase_q[in_s] <= rrts_pkg::PH_SLEEP;
                rrts_pkg::CMD_TWAIT: phase_q[in_s] <= rrts_pkg::PH_WAIT;
                rrts_pkg::CMD_SETCUR: cur_q <= {1'b0, in_s};
                default: ;
              endcase
            end
            if (in_cmd == rrts_pkg::CMD_SCHED) begin
              if (cur_q >= NoneSlot) begin
                okind_q <= rrts_pkg::KIND_NOCUR; oslot_q <= '0;
              end else if (nsel == cs) begin
                okind_q <= rrts_pkg::KIND_NOSW; oslot_q <= cs;
              end else begin
                okind_q <= rrts_pkg::KIND_SWITCH; oslot_q <= nsel;
                phase_q[nsel] <= rrts_pkg::PH_RUN;
                cur_q <= {1'b0, nsel};
                if (phase_q[cs] == rrts_pkg::PH_RUN) begin
                  phase_q[cs] <= rrts_pkg::PH_READY;
                  if (cs != idle_s) begin
                    // pop and push in one step; a pop always frees a place
                    if (fromq) ring_q[rtail] <= cs;
                    else if (rcount_q < NoneSlot) ring_q[rtail] <= cs;
                  end
                end
                if (fromq) begin
                  rhead_q <= (rhead_q == slot_t'(MAX_TASKS - 1)) ? '0 : rhead_q + 1'b1;
                  if (!(phase_q[cs] == rrts_pkg::PH_RUN && cs != idle_s))
                    rcount_q <= rcount_q - 1'b1;
                end else if (phase_q[cs] == rrts_pkg::PH_RUN && cs != idle_s &&
                             rcount_q < NoneSlot) begin
                  rcount_q <= rcount_q + 1'b1;
                end
              end
            end
            wprev_q <= NoneSlot;
            steps_q <= '0;
            wcur_q  <= (in_cmd == rrts_pkg::CMD_TCHECK) ? whead_q : shead_q;
          end
        end
        rrts_pkg::ST_WALK_EV: begin
          if (ev_go) begin
            steps_q <= steps_q + 1'b1;
            wcur_q  <= nxt;
            if (wake) begin
              if (wprev_q >= NoneSlot) begin
                if (mode) whead_q <= nxt; else shead_q <= nxt;
              end
              if (mode && wtail_q == wcur_q) wtail_q <= wprev_q;
              if (!mode && stail_q == wcur_q) stail_q <= wprev_q;
              phase_q[wc] <= rrts_pkg::PH_READY;
              if (rcount_q < NoneSlot) begin
                ring_q[rtail] <= wc;
                rcount_q <= rcount_q + 1'b1;
              end
              if (emit_now) begin
                nres_q <= nres_q + 1'b1;
                okind_q <= mode ? rrts_pkg::KIND_TIMEOUT : rrts_pkg::KIND_SLEPT;
                oslot_q <= wc;
              end
            end else begin
              wprev_q <= wcur_q;
            end
          end
        end
        rrts_pkg::ST_WALK_RD: ;
        rrts_pkg::ST_EMIT: ;
        rrts_pkg::ST_DONE: begin
          if (slot_q < NoneSlot) begin
            if (cmd_q == rrts_pkg::CMD_SLEEP) begin
              if (stail_q >= NoneSlot) shead_q <= slot_q;
              stail_q <= slot_q;
            end else if (cmd_q == rrts_pkg::CMD_TWAIT) begin
              if (wtail_q >= NoneSlot) whead_q <= slot_q;
              wtail_q <= slot_q;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      cmd_q   <= in_cmd;
      slot_q  <= slot_ok ? {1'b0, in_s} : NoneSlot;
      tv_q    <= in_tvm;
    end
  end

  // one pending result; a new wake sends the pending one out before it is taken in
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pend_q <= 1'b0;
    else if (state_q == rrts_pkg::ST_WALK_EV && wake &&
             nres_q < 5'(rrts_pkg::MaxResults)) pend_q <= 1'b1;
    else if (out_acc) pend_q <= 1'b0;
    else if (state_q == rrts_pkg::ST_IDLE && acc && in_cmd == rrts_pkg::CMD_SCHED)
      pend_q <= 1'b1;
  end

  assign m_axis_tvalid = (pend_q && (state_q == rrts_pkg::ST_EMIT)) || flush;
  assign m_axis_tdata  = 8'(oslot_q);
  assign m_axis_tuser  = okind_q;
  assign m_axis_tlast  = (state_q == rrts_pkg::ST_EMIT);

`ifndef SYNTH
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid) else $error("ready while result pending");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rcount_q <= NoneSlot) else $error("ready count overflow");
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |=> !m_axis_tvalid) else $error("result repeated");
`endif

endmodule
